[rtl/core/temporal_activity_accumulator_assert.svh]
// ----------------------------------------------------------------------------
// temporal activity accumulator assertion macros
// shared property forms, sampled on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_ACTIVITY_ACCUMULATOR_ASSERT_SVH
`define TEMPORAL_ACTIVITY_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define TACC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tacc assertion failed");

// next-cycle implication
`define TACC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tacc assertion failed");

`endif

[rtl/core/tacc_pkg.sv]
// ----------------------------------------------------------------------------
// tacc_pkg
// widths, register codes and queue entry type of the activity accumulator
// ----------------------------------------------------------------------------
package tacc_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int ACC_BITS       = 48;
    // per-item signed difference, up to four samples each side
    localparam int PART_BITS      = SAMPLE_BITS + 3;
    // sum of two column parts of a quad
    localparam int QUAD_BITS      = SAMPLE_BITS + 4;
    localparam int TERM_BITS      = SAMPLE_BITS + 3;
    localparam int ORDER_BITS     = 2;
    localparam int GAMMA_BITS     = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 4;
    localparam int Q_DEPTH        = 4;
    localparam int Q_IDX_BITS     = $clog2(Q_DEPTH);
    localparam int Q_PTR_BITS     = Q_IDX_BITS + 1;

    localparam logic [ORDER_BITS-1:0] ORDER_FIRST  = 2'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_SECOND = 2'd2;
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET  = 4'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORDER       = 2'd0,
        CFG_DOWN_SAMPLE = 2'd1,
        CFG_GAMMA       = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [TERM_BITS-1:0] term;
        logic                 last;
    } t_q_entry;

endpackage

[rtl/core/tacc_front.sv]
// ----------------------------------------------------------------------------
// tacc_front
// forms the absolute temporal difference of each item and pairs quad columns
// ----------------------------------------------------------------------------
module tacc_front import tacc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_second,
    input  logic                   i_down_sample,
    input  logic [SAMPLE_BITS-1:0] i_cur_top,
    input  logic [SAMPLE_BITS-1:0] i_cur_bottom,
    input  logic [SAMPLE_BITS-1:0] i_prev_top,
    input  logic [SAMPLE_BITS-1:0] i_prev_bottom,
    input  logic [SAMPLE_BITS-1:0] i_prev2_top,
    input  logic [SAMPLE_BITS-1:0] i_prev2_bottom,
    input  logic                   i_last,
    output logic                   o_push,
    output t_q_entry               o_entry
);

    localparam int EXT = PART_BITS - SAMPLE_BITS;

    logic                        r_phase;
    logic                        n_phase;
    logic signed [PART_BITS-1:0] r_partial;
    logic signed [PART_BITS-1:0] n_partial;

    logic signed [PART_BITS-1:0] s_c;
    logic signed [PART_BITS-1:0] s_p;
    logic signed [PART_BITS-1:0] s_q;
    logic signed [PART_BITS-1:0] part;
    logic signed [QUAD_BITS-1:0] sum;
    logic signed [QUAD_BITS-1:0] mag;
    logic                        add_term;

    always_comb begin
        s_c = $signed({{EXT{1'b0}}, i_cur_top});
        s_p = $signed({{EXT{1'b0}}, i_prev_top});
        s_q = $signed({{EXT{1'b0}}, i_prev2_top});
        if (i_down_sample) begin
            s_c = s_c + $signed({{EXT{1'b0}}, i_cur_bottom});
            s_p = s_p + $signed({{EXT{1'b0}}, i_prev_bottom});
            s_q = s_q + $signed({{EXT{1'b0}}, i_prev2_bottom});
        end
        if (i_second) begin
            part = s_c - (s_p <<< 1) + s_q;
        end else begin
            part = s_c - s_p;
        end
        sum = QUAD_BITS'(part);
        if (i_down_sample && r_phase) begin
            sum = sum + QUAD_BITS'(r_partial);
        end
        mag = (sum < 0) ? -sum : sum;
        // a pending half quad at block end is flushed with this item
        add_term = !i_down_sample || r_phase || i_last;
    end

    assign o_push        = i_accept && add_term;
    assign o_entry.term  = mag[TERM_BITS-1:0];
    assign o_entry.last  = i_last;

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        if (i_accept) begin
            if (i_down_sample && !r_phase && !i_last) begin
                n_phase   = 1'b1;
                n_partial = part;
            end else begin
                n_phase   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial <= n_partial;
    end

endmodule

[rtl/core/tacc_queue.sv]
// ----------------------------------------------------------------------------
// tacc_queue
// small fifo of difference terms between the front and the accumulator
// ----------------------------------------------------------------------------
`include "temporal_activity_accumulator_assert.svh"

module tacc_queue import tacc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_data,
    input  logic     i_pop,
    output logic     o_valid,
    output logic     o_full,
    output t_q_entry o_data
);

    t_q_entry              r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_PTR_BITS-1:0] n_rd_ptr;
    logic [Q_PTR_BITS-1:0] count;

    assign count    = r_wr_ptr - r_rd_ptr;
    assign o_valid  = (count != '0);
    assign o_full   = (count == Q_PTR_BITS'(Q_DEPTH));
    assign o_data   = r_mem[r_rd_ptr[Q_IDX_BITS-1:0]];
    assign n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
    assign n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[Q_IDX_BITS-1:0]] <= i_data;
        end
    end

    `TACC_ASSERT_SAME(a_no_push_when_full, o_full, !i_push)
    `TACC_ASSERT_SAME(a_no_pop_when_empty, !o_valid, !i_pop)
    `TACC_ASSERT_NEXT(a_count_grows, i_push && !i_pop, count == $past(count) + 1'b1)
    `TACC_ASSERT_NEXT(a_count_shrinks, i_pop && !i_push, count == $past(count) - 1'b1)

endmodule

[rtl/core/tacc_back.sv]
// ----------------------------------------------------------------------------
// tacc_back
// saturating accumulation of terms, block total scaled by gamma at block end
// ----------------------------------------------------------------------------
module tacc_back import tacc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_q_entry              i_q,
    output logic                  o_q_pop,
    input  logic [GAMMA_BITS-1:0] i_gamma,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ACC_BITS-1:0]   o_activity
);

    logic [ACC_BITS-1:0]            r_total;
    logic [ACC_BITS-1:0]            n_total;
    logic [ACC_BITS-1:0]            r_fin;
    logic                           r_fin_valid;
    logic                           n_fin_valid;
    logic [ACC_BITS-1:0]            r_out;
    logic                           r_out_valid;
    logic                           n_out_valid;

    logic [ACC_BITS:0]              sum;
    logic [ACC_BITS-1:0]            sat_sum;
    logic [ACC_BITS+GAMMA_BITS-1:0] prod;
    logic [ACC_BITS-1:0]            sat_prod;
    logic                           fin_move;

    assign sum      = {1'b0, r_total} + (ACC_BITS + 1)'(i_q.term);
    assign sat_sum  = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
    assign prod     = {{GAMMA_BITS{1'b0}}, r_fin} * {{ACC_BITS{1'b0}}, i_gamma};
    assign sat_prod = (|prod[ACC_BITS+GAMMA_BITS-1:ACC_BITS]) ? '1 : prod[ACC_BITS-1:0];

    assign fin_move = r_fin_valid && (!r_out_valid || !i_stall);
    // a last term waits while the finished total cannot move on
    assign o_q_pop  = i_q_valid && (!i_q.last || !r_fin_valid || fin_move);

    always_comb begin
        n_total     = r_total;
        n_fin_valid = fin_move ? 1'b0 : r_fin_valid;
        n_out_valid = (r_out_valid && i_stall) || fin_move;
        if (o_q_pop) begin
            if (i_q.last) begin
                n_total     = '0;
                n_fin_valid = 1'b1;
            end else begin
                n_total     = sat_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_fin_valid <= n_fin_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q.last) begin
            r_fin <= sat_sum;
        end
        if (fin_move) begin
            r_out <= sat_prod;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_activity = r_out;

endmodule

[rtl/core/temporal_activity_accumulator.sv]
// ----------------------------------------------------------------------------
// temporal_activity_accumulator
// block sum of absolute temporal differences, scaled by gamma
// ----------------------------------------------------------------------------
// Usage:
// input channel i_valid / o_stall carries co-located samples of the current,
// previous and second-previous frames in raster order, plus a last flag.
// a transfer happens on a clock edge with i_valid high and o_stall low.
// output channel o_valid / i_stall carries one activity value per block,
// produced for the item marked last; it holds while i_stall is high.
// configuration: i_cfg_valid / o_cfg_ready (always ready) write the difference
// order (index 0), down_sample (index 1) and gamma (index 2); only while idle.
// throughput: one item per clock while o_stall is low.
// after the last item's transfer the result passes through the term queue,
// the finished-total register and the gamma multiply register.
// a four-entry term queue lets input keep flowing for a while when the output
// stalls; o_stall rises once it is full.
// reset (synchronous, i_rst_n low) restores first order, down_sample 0,
// gamma 2 and clears the running total and any pending half quad.
// ----------------------------------------------------------------------------
module temporal_activity_accumulator import tacc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [SAMPLE_BITS-1:0]    i_cur_top,
    input  logic [SAMPLE_BITS-1:0]    i_cur_bottom,
    input  logic [SAMPLE_BITS-1:0]    i_prev_top,
    input  logic [SAMPLE_BITS-1:0]    i_prev_bottom,
    input  logic [SAMPLE_BITS-1:0]    i_prev2_top,
    input  logic [SAMPLE_BITS-1:0]    i_prev2_bottom,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ACC_BITS-1:0]       o_activity,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [ORDER_BITS-1:0] r_order;
    logic                  r_down_sample;
    logic [GAMMA_BITS-1:0] r_gamma;

    logic     accept;
    logic     push;
    logic     pop;
    logic     q_valid;
    logic     q_full;
    t_q_entry push_entry;
    t_q_entry q_head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign accept      = i_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order       <= ORDER_FIRST;
            r_down_sample <= 1'b0;
            r_gamma       <= GAMMA_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ORDER:       r_order       <= i_cfg_data[ORDER_BITS-1:0];
                CFG_DOWN_SAMPLE: r_down_sample <= i_cfg_data[0];
                CFG_GAMMA:       r_gamma       <= i_cfg_data[GAMMA_BITS-1:0];
                default: ;
            endcase
        end
    end

    tacc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        // codes two and three both select second order
        .i_second       (r_order[1]),
        .i_down_sample  (r_down_sample),
        .i_cur_top      (i_cur_top),
        .i_cur_bottom   (i_cur_bottom),
        .i_prev_top     (i_prev_top),
        .i_prev_bottom  (i_prev_bottom),
        .i_prev2_top    (i_prev2_top),
        .i_prev2_bottom (i_prev2_bottom),
        .i_last         (i_last),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    tacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_head)
    );

    tacc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q        (q_head),
        .o_q_pop    (pop),
        .i_gamma    (r_gamma),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_activity (o_activity)
    );

endmodule
